// File: sv/terminal_input_event_decoder_defines.svh
// ----------------------------------------------------------------------------
// terminal input event decoder assertion macros
// shared concurrent assertion forms for the decoder rtl
// ----------------------------------------------------------------------------
`ifndef TERMINAL_INPUT_EVENT_DECODER_DEFINES_SVH
`define TERMINAL_INPUT_EVENT_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TIED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tied assertion failed: same-cycle check");

// next-cycle implication, disabled while in reset
`define TIED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tied assertion failed: next-cycle check");

`endif

// File: sv/tied_pkg.sv
// ----------------------------------------------------------------------------
// tied_pkg
// types and constants of the terminal input event decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tied_pkg;

    // characters the parser looks for
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_UP        = 8'h41;
    localparam logic [7:0] CH_DOWN      = 8'h42;
    localparam logic [7:0] CH_PRESS     = 8'h4D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RELEASE   = 8'h6D;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_KEY   = 2'd1;
    localparam logic [1:0] EV_CLICK = 2'd2;

    // key codes
    localparam logic [1:0] KEY_CHAR  = 2'd0;
    localparam logic [1:0] KEY_ENTER = 2'd1;
    localparam logic [1:0] KEY_UP    = 2'd2;
    localparam logic [1:0] KEY_DOWN  = 2'd3;

    // mouse report field numbers
    localparam logic [1:0] FIELD_BUTTON = 2'd0;
    localparam logic [1:0] FIELD_COLUMN = 2'd1;
    localparam logic [1:0] FIELD_ROW    = 2'd2;

    localparam int unsigned OUT_COORD_W = 16;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_CSI   = 4'b0100,
        MODE_MOUSE = 4'b1000
    } t_mode;

    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_STOP   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]                     event_kind;
        logic [1:0]                     key_kind;
        logic [7:0]                     key_char;
        logic signed [OUT_COORD_W-1:0]  click_column;
        logic signed [OUT_COORD_W-1:0]  click_row;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_step;

endpackage

`default_nettype wire

// File: sv/tied_ifs.sv
// ----------------------------------------------------------------------------
// tied channel interfaces
// valid/ready channels for input bytes and decoded events
// ----------------------------------------------------------------------------
`default_nettype none

interface tied_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       input_closed;

    modport source (output valid, output data_byte, output input_closed, input ready);
    modport sink   (input valid, input data_byte, input input_closed, output ready);
endinterface

interface tied_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              event_kind;
    logic [1:0]                              key_kind;
    logic [7:0]                              key_char;
    logic signed [tied_pkg::OUT_COORD_W-1:0] click_column;
    logic signed [tied_pkg::OUT_COORD_W-1:0] click_row;

    modport source (output valid, output event_kind, output key_kind, output key_char,
                    output click_column, output click_row, input ready);
    modport sink   (input valid, input event_kind, input key_kind, input key_char,
                    input click_column, input click_row, output ready);
endinterface

`default_nettype wire

// File: sv/tied_field.sv
// ----------------------------------------------------------------------------
// tied_field
// one character step of the mouse report number parser
// ----------------------------------------------------------------------------
`default_nettype none

module tied_field #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic [7:0]                        i_byte,
    input  wire tied_pkg::t_phase                  i_phase,
    input  wire logic                              i_negative,
    input  wire logic [COORD_BITS-1:0]             i_accum,
    output tied_pkg::t_phase                       o_phase,
    output logic                                   o_negative,
    output logic [COORD_BITS-1:0]                  o_accum,
    output logic                                   o_feed_bad,
    output logic                                   o_value_bad,
    output logic [COORD_BITS-1:0]                  o_value,
    output logic [tied_pkg::OUT_COORD_W-1:0]       o_coord
);
    import tied_pkg::*;

    localparam int unsigned SUM_W = COORD_BITS + 4;
    localparam logic [SUM_W-1:0] LIM_NEG = SUM_W'(1) << (COORD_BITS - 1);
    localparam logic [SUM_W-1:0] LIM_POS = LIM_NEG - SUM_W'(1);

    logic                                   w_digit;
    logic                                   w_space;
    logic [SUM_W-1:0]                       w_wide;
    logic [SUM_W-1:0]                       w_next;
    logic [SUM_W-1:0]                       w_lim;
    logic [COORD_BITS+OUT_COORD_W-1:0]      w_ext;

    assign w_wide = {4'b0000, i_accum};
    // accum * 10 + digit as two shifts and two adds
    assign w_next = (w_wide << 3) + (w_wide << 1) + SUM_W'(i_byte[3:0]);
    assign w_lim  = i_negative ? LIM_NEG : LIM_POS;

    always_comb begin
        w_digit     = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        w_space     = i_byte inside {CH_SPACE, [CH_TAB:CH_CR]};
        o_phase     = i_phase;
        o_negative  = i_negative;
        o_accum     = i_accum;
        o_feed_bad  = 1'b0;
        if ((i_phase == PH_SPACE) && w_space) begin
            // skip leading whitespace
        end else if ((i_phase == PH_SPACE) && ((i_byte == CH_PLUS) || (i_byte == CH_MINUS))) begin
            o_negative = (i_byte == CH_MINUS);
            o_phase    = PH_SIGN;
        end else if ((i_phase != PH_STOP) && w_digit) begin
            o_phase = PH_DIGITS;
            if (w_next > w_lim) begin
                o_feed_bad = 1'b1;
            end else begin
                o_accum = w_next[COORD_BITS-1:0];
            end
        end else begin
            o_feed_bad = (i_phase == PH_SPACE) || (i_phase == PH_SIGN);
            o_phase    = PH_STOP;
        end
    end

    // value of the field as it stands, and whether it had a digit
    assign o_value_bad = (i_phase == PH_SPACE) || (i_phase == PH_SIGN);
    assign o_value     = i_negative ? (COORD_BITS'(0) - i_accum) : i_accum;
    assign w_ext       = {{OUT_COORD_W{1'b0}}, o_value};
    assign o_coord     = w_ext[OUT_COORD_W-1:0];

endmodule

`default_nettype wire

// File: sv/tied_core.sv
// ----------------------------------------------------------------------------
// tied_core
// parser state and per-byte decode of keys and mouse reports
// ----------------------------------------------------------------------------
`default_nettype none
`include "terminal_input_event_decoder_defines.svh"

module tied_core #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_closed,
    output tied_pkg::t_step     o_step
);
    import tied_pkg::*;

    t_mode                      r_mode,        n_mode;
    logic [1:0]                 r_field_index, n_field_index;
    t_phase                     r_phase,       n_phase;
    logic                       r_negative,    n_negative;
    logic [COORD_BITS-1:0]      r_accum,       n_accum;
    logic                       r_invalid,     n_invalid;
    logic                       r_button_nz,   n_button_nz;
    logic [OUT_COORD_W-1:0]     r_saved_col,   n_saved_col;

    t_phase                     w_feed_phase;
    logic                       w_feed_negative;
    logic [COORD_BITS-1:0]      w_feed_accum;
    logic                       w_feed_bad;
    logic                       w_value_bad;
    logic [COORD_BITS-1:0]      w_value;
    logic [OUT_COORD_W-1:0]     w_coord;

    tied_field #(
        .COORD_BITS (COORD_BITS)
    ) u_field (
        .i_byte      (i_byte),
        .i_phase     (r_phase),
        .i_negative  (r_negative),
        .i_accum     (r_accum),
        .o_phase     (w_feed_phase),
        .o_negative  (w_feed_negative),
        .o_accum     (w_feed_accum),
        .o_feed_bad  (w_feed_bad),
        .o_value_bad (w_value_bad),
        .o_value     (w_value),
        .o_coord     (w_coord)
    );

    always_comb begin
        n_mode        = r_mode;
        n_field_index = r_field_index;
        n_phase       = r_phase;
        n_negative    = r_negative;
        n_accum       = r_accum;
        n_invalid     = r_invalid;
        n_button_nz   = r_button_nz;
        n_saved_col   = r_saved_col;
        o_step        = '0;
        if (i_closed) begin
            n_mode      = MODE_IDLE;
            o_step.emit = 1'b1;
        end else begin
            case (r_mode)
                MODE_IDLE: begin
                    if ((i_byte == CH_CR) || (i_byte == CH_LF)) begin
                        o_step.emit              = 1'b1;
                        o_step.result.event_kind = EV_KEY;
                        o_step.result.key_kind   = KEY_ENTER;
                    end else if (i_byte == CH_ESC) begin
                        n_mode = MODE_ESC;
                    end else begin
                        o_step.emit              = 1'b1;
                        o_step.result.event_kind = EV_KEY;
                        o_step.result.key_kind   = KEY_CHAR;
                        o_step.result.key_char   = i_byte;
                    end
                end
                MODE_ESC: begin
                    if (i_byte == CH_LBRACKET) begin
                        n_mode = MODE_CSI;
                    end else begin
                        n_mode      = MODE_IDLE;
                        o_step.emit = 1'b1;
                    end
                end
                MODE_CSI: begin
                    n_mode = MODE_IDLE;
                    if (i_byte == CH_LT) begin
                        n_mode        = MODE_MOUSE;
                        n_field_index = FIELD_BUTTON;
                        n_phase       = PH_SPACE;
                        n_negative    = 1'b0;
                        n_accum       = '0;
                        n_invalid     = 1'b0;
                        n_button_nz   = 1'b0;
                        n_saved_col   = '0;
                    end else begin
                        o_step.emit = 1'b1;
                        if (i_byte == CH_UP) begin
                            o_step.result.event_kind = EV_KEY;
                            o_step.result.key_kind   = KEY_UP;
                        end else if (i_byte == CH_DOWN) begin
                            o_step.result.event_kind = EV_KEY;
                            o_step.result.key_kind   = KEY_DOWN;
                        end
                    end
                end
                MODE_MOUSE: begin
                    if (i_byte == CH_RELEASE) begin
                        n_mode      = MODE_IDLE;
                        o_step.emit = 1'b1;
                    end else if (i_byte == CH_PRESS) begin
                        n_mode      = MODE_IDLE;
                        o_step.emit = 1'b1;
                        // click only with all three fields, no error and button zero
                        if ((r_field_index == FIELD_ROW) && !r_invalid && !w_value_bad
                                && !r_button_nz) begin
                            o_step.result.event_kind   = EV_CLICK;
                            o_step.result.click_column = signed'(r_saved_col);
                            o_step.result.click_row    = signed'(w_coord);
                        end
                    end else if ((i_byte == CH_SEMI) && (r_field_index < FIELD_ROW)) begin
                        n_invalid = r_invalid | w_value_bad;
                        if (r_field_index == FIELD_BUTTON) begin
                            n_button_nz = (w_value != '0);
                        end else begin
                            n_saved_col = w_coord;
                        end
                        n_field_index = r_field_index + 2'd1;
                        n_phase       = PH_SPACE;
                        n_negative    = 1'b0;
                        n_accum       = '0;
                    end else begin
                        n_phase    = w_feed_phase;
                        n_negative = w_feed_negative;
                        n_accum    = w_feed_accum;
                        n_invalid  = r_invalid | w_feed_bad;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_field_index <= FIELD_BUTTON;
            r_phase       <= PH_SPACE;
            r_negative    <= 1'b0;
            r_accum       <= '0;
            r_invalid     <= 1'b0;
            r_button_nz   <= 1'b0;
            r_saved_col   <= '0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_field_index <= n_field_index;
            r_phase       <= n_phase;
            r_negative    <= n_negative;
            r_accum       <= n_accum;
            r_invalid     <= n_invalid;
            r_button_nz   <= n_button_nz;
            r_saved_col   <= n_saved_col;
        end
    end

    `TIED_ASSERT_NEXT(a_closed_to_idle, i_clk, i_rst_n, i_fire && i_closed, r_mode == MODE_IDLE)
    `TIED_ASSERT_NOW(a_index_range, i_clk, i_rst_n, 1'b1, r_field_index <= FIELD_ROW)
    `TIED_ASSERT_NOW(a_click_source, i_clk, i_rst_n, i_fire && o_step.emit && (o_step.result.event_kind == EV_CLICK), (r_mode == MODE_MOUSE) && (r_field_index == FIELD_ROW))

endmodule

`default_nettype wire

// File: sv/terminal_input_event_decoder.sv
// ----------------------------------------------------------------------------
// terminal_input_event_decoder
// decodes terminal input bytes into key and left mouse click events
// ----------------------------------------------------------------------------
// Takes one terminal byte per beat and returns at most one event per byte:
// CR or LF is an enter key, ESC [ A and ESC [ B are up and down arrows, any
// other plain byte is a character key, and any other escape sequence is a
// none event. ESC [ < opens an SGR mouse report "b;x;y" closed by 'M' or 'm';
// only an 'M' report with button zero and three well-formed numbers that fit
// in COORD_BITS signed bits gives a click with its column and row (reported
// in 16 bits). A closed-input beat aborts any pending sequence and yields a
// none event. Bytes that only advance a sequence (ESC, ESC [, ESC [ <, and
// every byte inside a report before its terminator) produce no event.
// Rate: one byte accepted every cycle; a byte passes the input register and
// then the parser into the result register. Only a stalled result holding
// back a byte that produces another result stops intake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "terminal_input_event_decoder_defines.svh"

module terminal_input_event_decoder #(
    parameter int unsigned COORD_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tied_in_if.sink         i_in,
    tied_out_if.source      o_out
);
    import tied_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_closed;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_step      w_step;
    logic       w_advance;

    // the held byte moves on unless it makes a result and the result slot is
    // still occupied by one the sink has not taken
    assign w_advance  = r_in_valid && (!w_step.emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte   <= i_in.data_byte;
            r_in_closed <= i_in.input_closed;
        end
    end

    // parser: state update and event decode for the held byte
    tied_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_byte   (r_in_byte),
        .i_closed (r_in_closed),
        .o_step   (w_step)
    );

    // result register, loaded when a byte produces an event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_step.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step.emit) begin
            r_out <= w_step.result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_out.event_kind;
    assign o_out.key_kind     = r_out.key_kind;
    assign o_out.key_char     = r_out.key_char;
    assign o_out.click_column = r_out.click_column;
    assign o_out.click_row    = r_out.click_row;

    // key fields only carry data on key events
    `TIED_ASSERT_NOW(a_key_fields_clear, i_clk, i_rst_n, o_out.valid && (o_out.event_kind != EV_KEY), (o_out.key_kind == KEY_CHAR) && (o_out.key_char == 8'h00))
    // coordinates only carry data on click events
    `TIED_ASSERT_NOW(a_click_fields_clear, i_clk, i_rst_n, o_out.valid && (o_out.event_kind != EV_CLICK), (o_out.click_column == '0) && (o_out.click_row == '0))
    // a new result never lands on one still waiting for the sink
    `TIED_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_advance && w_step.emit, !r_out_valid || o_out.ready)

endmodule

`default_nettype wire

// File: verif/tb_terminal_input_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_input_event_decoder
// self-checking bench: directed byte table, then random key and mouse traffic
// ----------------------------------------------------------------------------
// bytes go in over the input channel with random gaps
// every accepted beat runs through a bit-accurate decoder model kept here
// predicted events wait in a queue, oldest first
// each event beat from the block is compared field by field with the oldest
// receiver stalls at random, and once holds off long enough to back up input
// ----------------------------------------------------------------------------
`default_nettype none

module tb_terminal_input_event_decoder;

    import tied_pkg::*;

    localparam int unsigned CLK_PERIOD   = 4;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned COORD_BITS   = 16;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DIRECTED_N   = 31;

    // largest magnitudes a coordinate may take for each sign
    localparam int unsigned MAG_POS = 2 ** (COORD_BITS - 1) - 1;
    localparam int unsigned MAG_NEG = 2 ** (COORD_BITS - 1);

    localparam t_result NO_EVENT = '{EV_NONE, KEY_CHAR, 8'h00, 16'sh0000, 16'sh0000};

    // one input beat; typed rows carry their expected event in the row itself
    typedef struct packed {
        logic [7:0] data;
        logic       closed;
        logic       typed;
        logic       emit;
        t_result    outcome;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // clock, reset, channels
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    tied_in_if  in_ch ();
    tied_out_if out_ch ();

    // bench-side drivers, all known from time zero
    logic       src_valid  = 1'b0;
    logic [7:0] src_byte   = 8'h00;
    logic       src_closed = 1'b0;
    logic       sink_ready = 1'b0;
    t_stim_row  cur_row    = '0;

    assign in_ch.valid        = src_valid;
    assign in_ch.data_byte    = src_byte;
    assign in_ch.input_closed = src_closed;
    assign out_ch.ready       = sink_ready;

    terminal_input_event_decoder #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------------
    // decoder model state
    // ------------------------------------------------------------------------
    t_mode       dec_mode    = MODE_IDLE;
    logic [1:0]  dec_field   = FIELD_BUTTON;  // which report number is being read
    t_phase      dec_phase   = PH_SPACE;
    logic        dec_neg     = 1'b0;
    int unsigned dec_mag     = 0;             // magnitude of the number so far
    logic        dec_bad     = 1'b0;          // report can no longer give a click
    logic        dec_btn_set = 1'b0;          // button number was nonzero
    logic [15:0] dec_column  = 16'h0000;

    t_result pending_events[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned items_sent     = 0;
    logic        src_calm       = 1'b0;
    logic        sink_calm      = 1'b0;
    logic        hold_off       = 1'b0;
    logic        in_random_phase = 1'b0;
    int unsigned sink_wait      = 0;

    function automatic void clear_field();
        dec_phase = PH_SPACE;
        dec_neg   = 1'b0;
        dec_mag   = 0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // one character of a report number, stoi style
    function automatic void take_number_char(input logic [7:0] c);
        logic        digit;
        int unsigned lim;
        int unsigned nxt;
        digit = c >= CH_ZERO && c <= CH_NINE;
        if (dec_phase == PH_SPACE) begin
            if (is_blank(c)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
                dec_neg   = (c == CH_MINUS);
                dec_phase = PH_SIGN;
                return;
            end
        end
        if (dec_phase != PH_STOP && digit) begin
            lim = dec_neg ? MAG_NEG : MAG_POS;
            nxt = dec_mag * 10 + int'(c - CH_ZERO);
            dec_phase = PH_DIGITS;
            // overflow poisons the report but keeps the old magnitude
            if (nxt > lim) dec_bad = 1'b1;
            else dec_mag = nxt;
            return;
        end
        // anything else ends the number; no digit seen means a bad field
        if (dec_phase == PH_SPACE || dec_phase == PH_SIGN) dec_bad = 1'b1;
        dec_phase = PH_STOP;
    endfunction

    function automatic logic [15:0] close_field();
        logic [15:0] mag;
        mag = dec_mag[15:0];
        if (dec_phase == PH_SPACE || dec_phase == PH_SIGN) dec_bad = 1'b1;
        return dec_neg ? -mag : mag;
    endfunction

    // predicts the event, if any, that one accepted beat causes
    function automatic logic decode_byte(input logic [7:0] c, input logic closed,
                                         output t_result ev);
        logic [15:0] v;
        ev = NO_EVENT;
        if (closed) begin
            dec_mode = MODE_IDLE;
            return 1'b1;
        end
        case (dec_mode)
            MODE_IDLE: begin
                if (c == CH_CR || c == CH_LF) begin
                    ev.event_kind = EV_KEY;
                    ev.key_kind   = KEY_ENTER;
                end else if (c == CH_ESC) begin
                    dec_mode = MODE_ESC;
                    return 1'b0;
                end else begin
                    ev.event_kind = EV_KEY;
                    ev.key_char   = c;
                end
                return 1'b1;
            end
            MODE_ESC: begin
                if (c == CH_LBRACKET) begin
                    dec_mode = MODE_CSI;
                    return 1'b0;
                end
                dec_mode = MODE_IDLE;
                return 1'b1;
            end
            MODE_CSI: begin
                dec_mode = MODE_IDLE;
                if (c == CH_LT) begin
                    dec_mode    = MODE_MOUSE;
                    dec_field   = FIELD_BUTTON;
                    clear_field();
                    dec_bad     = 1'b0;
                    dec_btn_set = 1'b0;
                    dec_column  = 16'h0000;
                    return 1'b0;
                end
                if (c == CH_UP) begin
                    ev.event_kind = EV_KEY;
                    ev.key_kind   = KEY_UP;
                end else if (c == CH_DOWN) begin
                    ev.event_kind = EV_KEY;
                    ev.key_kind   = KEY_DOWN;
                end
                return 1'b1;
            end
            default: ;
        endcase

        // inside a mouse report every byte is report text
        if (c == CH_RELEASE) begin
            dec_mode = MODE_IDLE;
            return 1'b1;
        end
        if (c == CH_PRESS) begin
            dec_mode = MODE_IDLE;
            if (dec_field != FIELD_ROW) return 1'b1;
            v = close_field();
            if (!dec_bad && !dec_btn_set) begin
                ev.event_kind   = EV_CLICK;
                ev.click_column = dec_column;
                ev.click_row    = v;
            end
            return 1'b1;
        end
        if (c == CH_SEMI && dec_field != FIELD_ROW) begin
            v = close_field();
            if (dec_field == FIELD_BUTTON) dec_btn_set = (v != 16'h0000);
            else dec_column = v;
            dec_field = dec_field + 2'd1;
            clear_field();
            return 1'b0;
        end
        take_number_char(c);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // directed table: extremes, every key, abort and closed cases, one click
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_N] = '{
        '{8'h00,       1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_CHAR, 8'h00, 16'sh0000, 16'sh0000}},
        '{8'hFF,       1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_CHAR, 8'hFF, 16'sh0000, 16'sh0000}},
        '{CH_CR,       1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_ENTER, 8'h00, 16'sh0000, 16'sh0000}},
        '{CH_LF,       1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_ENTER, 8'h00, 16'sh0000, 16'sh0000}},
        '{CH_ESC,      1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_LBRACKET, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_UP,       1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_UP, 8'h00, 16'sh0000, 16'sh0000}},
        '{CH_ESC,      1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_LBRACKET, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_DOWN,     1'b0, 1'b1, 1'b1, '{EV_KEY, KEY_DOWN, 8'h00, 16'sh0000, 16'sh0000}},
        // escape followed by a plain letter is swallowed
        '{CH_ESC,      1'b0, 1'b1, 1'b0, NO_EVENT},
        '{8'h71,       1'b0, 1'b1, 1'b1, NO_EVENT},
        // closed input ignores the byte
        '{8'hFF,       1'b1, 1'b1, 1'b1, NO_EVENT},
        // report "0;-32768;32767M" carries both coordinate extremes
        '{CH_ESC,      1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_LBRACKET, 1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_LT,       1'b0, 1'b1, 1'b0, NO_EVENT},
        '{CH_ZERO,     1'b0, 1'b0, 1'b0, NO_EVENT},
        '{CH_SEMI,     1'b0, 1'b0, 1'b0, NO_EVENT},
        '{CH_MINUS,    1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h33,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h32,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h37,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h36,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h38,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{CH_SEMI,     1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h33,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h32,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h37,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h36,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{8'h37,       1'b0, 1'b0, 1'b0, NO_EVENT},
        '{CH_PRESS,    1'b0, 1'b1, 1'b1, '{EV_CLICK, KEY_CHAR, 8'h00, 16'sh8000, 16'sh7FFF}}
    };

    // ------------------------------------------------------------------------
    // gap lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    // offer one beat and hold it until the block takes it
    task automatic send_row(input t_stim_row row);
        int unsigned gap;
        gap = pick_gap(src_calm);
        if (gap != 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid  <= 1'b1;
        src_byte   <= row.data;
        src_closed <= row.closed;
        cur_row    <= row;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input logic [7:0] b);
        t_stim_row row;
        row      = '0;
        row.data = b;
        send_row(row);
    endtask

    task automatic send_close();
        t_stim_row row;
        row        = '0;
        row.data   = 8'($urandom_range(0, 255));
        row.closed = 1'b1;
        send_row(row);
    endtask

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(0, 1) == 0) return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    // one report number: blanks, sign, digits, and now and then junk after it
    task automatic send_number(input logic is_button);
        int unsigned n;
        int unsigned r;
        int unsigned v;
        int unsigned nd;
        logic [3:0]  dg [8];
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) send_text(pick_blank());
        r = $urandom_range(0, 9);
        if (r < 2) send_text(CH_MINUS);
        else if (r == 2) send_text(CH_PLUS);
        r = $urandom_range(0, 19);
        // a field with no digits at all
        if (r == 16) return;
        if (is_button) v = (r < 14) ? 0 : $urandom_range(1, 64);
        else if (r < 11) v = $urandom_range(0, 300);
        else if (r == 11) v = MAG_POS;
        else if (r == 12) v = MAG_NEG;
        else if (r == 13) v = $urandom_range(MAG_NEG + 1, 40000);
        else if (r == 14) v = $urandom_range(65535, 65536);
        else if (r == 15) v = $urandom_range(0, 99999);
        else if (r == 17) v = $urandom_range(0, 50);
        else v = $urandom_range(0, MAG_NEG);
        if (r == 17) begin
            send_text(CH_ZERO);
            send_text(CH_ZERO);
        end
        nd = 0;
        do begin
            dg[nd] = 4'(v % 10);
            v = v / 10;
            nd++;
        end while (v != 0);
        while (nd != 0) begin
            nd--;
            send_text(CH_ZERO + 8'(dg[nd]));
        end
        if ($urandom_range(0, 9) == 0) send_text(8'($urandom_range(32, 126)));
    endtask

    // mostly well-formed reports; some lose a field, gain a separator, or never end
    task automatic send_mouse_report();
        int unsigned seps;
        int unsigned r;
        send_text(CH_ESC);
        send_text(CH_LBRACKET);
        send_text(CH_LT);
        send_number(1'b1);
        r = $urandom_range(0, 19);
        seps = (r == 0) ? 0 : (r == 1) ? 1 : 2;
        if (seps >= 1) begin
            send_text(CH_SEMI);
            send_number(1'b0);
        end
        if (seps == 2) begin
            send_text(CH_SEMI);
            send_number(1'b0);
        end
        // a third separator is just row text
        if ($urandom_range(0, 9) == 0) begin
            send_text(CH_SEMI);
            send_number(1'b0);
        end
        if ($urandom_range(0, 9) == 0) send_text(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 75) send_text(CH_PRESS);
        else if (r < 87) send_text(CH_RELEASE);
        else if (r < 94) send_close();
        // otherwise the report stays open and swallows what follows
    endtask

    task automatic send_random_sequence();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_mouse_report();
        end else if (r < 60) begin
            send_text(8'($urandom_range(0, 255)));
        end else if (r < 68) begin
            send_text(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
        end else if (r < 80) begin
            send_text(CH_ESC);
            send_text(CH_LBRACKET);
            case ($urandom_range(0, 2))
                0: send_text(CH_UP);
                1: send_text(CH_DOWN);
                default: send_text(8'($urandom_range(0, 255)));
            endcase
        end else if (r < 86) begin
            send_text(CH_ESC);
            send_text(8'($urandom_range(0, 255)));
        end else if (r < 91) begin
            send_close();
        end else if (r < 96) begin
            // closed input cutting a sequence short
            send_text(CH_ESC);
            if ($urandom_range(0, 1) == 0) send_text(CH_LBRACKET);
            send_close();
        end else begin
            // report full of noise
            send_text(CH_ESC);
            send_text(CH_LBRACKET);
            send_text(CH_LT);
            repeat ($urandom_range(1, 6)) send_text(8'($urandom_range(0, 255)));
            send_text(CH_PRESS);
        end
    endtask

    initial begin
        int unsigned next_mood;
        next_mood = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++) send_row(directed_rows[i]);

        in_random_phase = 1'b1;
        while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
            // stretches of back-to-back beats between gappy ones
            if (items_sent >= next_mood) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                next_mood = items_sent + 48;
            end
            send_random_sequence();
        end
        src_valid <= 1'b0;

        // drain, then give a stray extra event time to show up
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (cycle_count % 128 == 0) sink_calm <= ($urandom_range(0, 3) == 0);
        if (hold_off) begin
            sink_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait  <= sink_wait - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= 1'b1;
            sink_wait  <= pick_gap(sink_calm);
        end
    end

    // long back-pressure while the sender keeps offering beats
    initial begin
        wait (in_random_phase);
        repeat (50) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic check_event(input t_result want, input t_result got);
        if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
            mismatch_count++;
        end
        if (got.key_kind !== want.key_kind) begin
            $error("key_kind: expected %0d, got %0d", want.key_kind, got.key_kind);
            mismatch_count++;
        end
        if (got.key_char !== want.key_char) begin
            $error("key_char: expected %0h, got %0h", want.key_char, got.key_char);
            mismatch_count++;
        end
        if (got.click_column !== want.click_column) begin
            $error("click_column: expected %0d, got %0d", want.click_column,
                   got.click_column);
            mismatch_count++;
        end
        if (got.click_row !== want.click_row) begin
            $error("click_row: expected %0d, got %0d", want.click_row, got.click_row);
            mismatch_count++;
        end
    endtask

    // output side first, then the beat taken at the same edge
    always @(posedge clk) begin : event_tracker
        t_result got;
        t_result predicted;
        logic    fires;
        if (out_ch.valid && out_ch.ready) begin
            got.event_kind   = out_ch.event_kind;
            got.key_kind     = out_ch.key_kind;
            got.key_char     = out_ch.key_char;
            got.click_column = out_ch.click_column;
            got.click_row    = out_ch.click_row;
            if (pending_events.size() == 0) begin
                $error("event_kind: expected no event, got %0d", got.event_kind);
                mismatch_count++;
            end else begin
                check_event(pending_events.pop_front(), got);
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready) begin
            fires = decode_byte(in_ch.data_byte, in_ch.input_closed, predicted);
            // typed rows carry their own expectation
            if (cur_row.typed) begin
                fires     = cur_row.emit;
                predicted = cur_row.outcome;
            end
            if (fires) pending_events.insert(pending_events.size(), predicted);
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire
